// File: hw/rtl/rssi_voter_select_assert.svh
// Assertion macros used by the voter select RTL.
`ifndef RSSI_VOTER_SELECT_ASSERT_SVH
`define RSSI_VOTER_SELECT_ASSERT_SVH
`ifndef ASSERT_OFF
// Condition must hold at every clock edge outside reset.
`define RVS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rssi voter select check failed");
// When pre holds, post must hold at the next clock edge.
`define RVS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rssi voter select check failed");
`else
`define RVS_ASSERT(lbl, cond)
`define RVS_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/rvs_pkg.sv
// Types and constants shared by the voter select block.
package rvs_pkg;

    localparam int MAX_LINKS_DEF = 16;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_LOCAL = 2'd1,
        KIND_LINK  = 2'd2
    } winner_kind_t;

    typedef struct packed {
        logic       link_present;
        logic [3:0] link_slot;
        logic       link_receiving;
        logic [7:0] link_rssi;
        logic       local_keyed;
        logic [7:0] local_rssi;
        logic       last_in_round;
    } in_item_t;

    typedef struct packed {
        logic [1:0] winner_kind;
        logic [3:0] winner_slot;
        logic [7:0] vote_level;
        logic [7:0] best_rssi;
        logic       new_winner;
    } result_t;

endpackage

// File: hw/rtl/rvs_in_if.sv
// Valid/ready channel carrying one link report item.
interface rvs_in_if;
    logic              valid;
    logic              ready;
    rvs_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rvs_out_if.sv
// Valid/ready channel carrying one voting result.
interface rvs_out_if;
    logic             valid;
    logic             ready;
    rvs_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/rvs_in_stage.sv
// Input register stage for link report items.
module rvs_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    rvs_in_if.sink            item,
    input  logic              take,
    output logic              s1_valid,
    output rvs_pkg::in_item_t s1_item
);
    import rvs_pkg::*;

    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    logic     accept;

    // The stage refills in the same cycle that its item moves on.
    assign item.ready = !s1_valid_reg || take;
    assign accept     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item.data;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;
endmodule

// File: hw/rtl/rvs_vote.sv
// Round accumulation, winner election and result register.
`include "rssi_voter_select_assert.svh"
module rvs_vote #(
    parameter int MAX_LINKS = rvs_pkg::MAX_LINKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        voter_margin,
    input  logic              s1_valid,
    input  rvs_pkg::in_item_t s1_item,
    output logic              take,
    rvs_out_if.source         result
);
    import rvs_pkg::*;

    winner_kind_t kind_reg, kind_next;
    logic [3:0]   win_slot_reg, win_slot_next;
    logic [7:0]   max_reg, max_next;
    logic [3:0]   best_slot_reg, best_slot_next;
    logic         has_link_reg, has_link_next;
    logic [7:0]   seen_reg, seen_next;
    logic         round_open_reg;
    logic         keyed_reg, keyed_next;
    logic [7:0]   lrssi_reg, lrssi_next;
    logic         out_valid_reg;
    result_t      out_reg, out_next;

    logic       first;
    logic       hit;
    logic [7:0] voted;
    logic [8:0] limit;
    logic       elect;

    // A non-final item always moves on; a final one needs room at the output.
    assign take = s1_valid && (!s1_item.last_in_round || !out_valid_reg || result.ready);

    always_comb
    begin
        first = !round_open_reg;
        if (first)
        begin
            keyed_next     = s1_item.local_keyed;
            lrssi_next     = s1_item.local_rssi;
            max_next       = s1_item.local_keyed ? s1_item.local_rssi : 8'd0;
            best_slot_next = 4'd0;
            has_link_next  = 1'b0;
            seen_next      = 8'd0;
        end
        else
        begin
            keyed_next     = keyed_reg;
            lrssi_next     = lrssi_reg;
            max_next       = max_reg;
            best_slot_next = best_slot_reg;
            has_link_next  = has_link_reg;
            seen_next      = seen_reg;
        end

        hit = s1_item.link_present && s1_item.link_receiving &&
              (32'(s1_item.link_slot) < 32'(MAX_LINKS));
        if (hit)
        begin
            if (s1_item.link_rssi > max_next)
            begin
                max_next       = s1_item.link_rssi;
                best_slot_next = s1_item.link_slot;
                has_link_next  = 1'b1;
            end
            if (kind_reg == KIND_LINK && s1_item.link_slot == win_slot_reg)
            begin
                seen_next = s1_item.link_rssi;
            end
        end

        // Refreshed strength of the sitting winner.
        case (kind_reg)
            KIND_LOCAL: voted = keyed_next ? lrssi_next : 8'd0;
            KIND_LINK:  voted = seen_next;
            default:    voted = 8'd0;
        endcase

        limit = {1'b0, voted} + {1'b0, voter_margin};
        elect = (voted == 8'd0) || (kind_reg == KIND_NONE) || ({1'b0, max_next} > limit);

        kind_next     = kind_reg;
        win_slot_next = win_slot_reg;
        if (elect)
        begin
            if (has_link_next)
            begin
                kind_next     = KIND_LINK;
                win_slot_next = best_slot_next;
            end
            else
            begin
                kind_next     = keyed_next ? KIND_LOCAL : KIND_NONE;
                win_slot_next = 4'd0;
            end
            voted = max_next;
        end

        out_next.winner_kind = kind_next;
        out_next.winner_slot = (kind_next == KIND_LINK) ? win_slot_next : 4'd0;
        out_next.vote_level  = voted;
        out_next.best_rssi   = max_next;
        out_next.new_winner  = elect;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg       <= KIND_NONE;
            win_slot_reg   <= 4'd0;
            max_reg        <= 8'd0;
            best_slot_reg  <= 4'd0;
            has_link_reg   <= 1'b0;
            seen_reg       <= 8'd0;
            round_open_reg <= 1'b0;
            keyed_reg      <= 1'b0;
            lrssi_reg      <= 8'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                max_reg        <= max_next;
                best_slot_reg  <= best_slot_next;
                has_link_reg   <= has_link_next;
                seen_reg       <= seen_next;
                keyed_reg      <= keyed_next;
                lrssi_reg      <= lrssi_next;
                round_open_reg <= !s1_item.last_in_round;
                if (s1_item.last_in_round)
                begin
                    kind_reg     <= kind_next;
                    win_slot_reg <= win_slot_next;
                end
            end
            if (take && s1_item.last_in_round)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s1_item.last_in_round)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    `RVS_ASSERT_NEXT(a_round_closes, take && s1_item.last_in_round, !round_open_reg)
    `RVS_ASSERT_NEXT(a_keep_winner, take && s1_item.last_in_round && !elect, $stable(kind_reg) && $stable(win_slot_reg))
    `RVS_ASSERT(a_slot_only_link, !out_valid_reg || out_reg.winner_kind == KIND_LINK || out_reg.winner_slot == 4'd0)
    `RVS_ASSERT(a_elect_takes_best, !out_valid_reg || !out_reg.new_winner || out_reg.vote_level == out_reg.best_rssi)
endmodule

// File: hw/rtl/rssi_voter_select.sv
// Top level of the receiver voting comparator with hysteresis.
// Link reports arrive on the item channel, one transfer per report, and a
// voting round is the run of transfers that ends with last_in_round set.
// The first transfer of a round also samples the local receiver's keyed
// flag and strength. Each round yields exactly one transfer on the result
// channel: the voted source, its slot, the held voted strength, the best
// strength of the round and whether the round re-elected the winner.
// The margin register sets how far a challenger must exceed the held
// strength before the winner changes; write it only while the block idles.
// A closing report is first held in the input register and, once the result
// channel has room, loaded into the result register, from which the result is
// offered. Throughput is one report per cycle unless a closing report waits
// for the result channel, set by the single compare and update of the running
// maximum between the two registers.
// Reset clears the winner, the round state and the margin, so the next
// transfer starts a new round with no sitting winner.
// When the receiver stalls, reports that do not close a round keep flowing;
// a closing report waits in the input register until the pending result
// has been taken, and the item channel stalls for as long as it waits.
module rssi_voter_select #(
    parameter int MAX_LINKS = rvs_pkg::MAX_LINKS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    rvs_in_if.sink     item,
    rvs_out_if.source  result
);
    import rvs_pkg::*;

    logic [7:0] voter_margin_reg;
    logic       s1_valid;
    in_item_t   s1_item;
    logic       take;

    // The user is to write the margin register only between rounds; the block itself does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voter_margin_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            voter_margin_reg <= cfg_wdata;
        end
    end

    rvs_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .take     (take),
        .s1_valid (s1_valid),
        .s1_item  (s1_item)
    );

    rvs_vote #(
        .MAX_LINKS (MAX_LINKS)
    ) u_vote (
        .clk          (clk),
        .rst_n        (rst_n),
        .voter_margin (voter_margin_reg),
        .s1_valid     (s1_valid),
        .s1_item      (s1_item),
        .take         (take),
        .result       (result)
    );
endmodule

// File: bench/rssi_voter_select_checker.sv
`timescale 1ns / 1ps
// Checker for the voter select block: predicts every round's result and compares it.
module rssi_voter_select_checker #(
    parameter int MAX_LINKS = rvs_pkg::MAX_LINKS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    rvs_in_if          item,
    rvs_out_if         result,
    output int         mismatches,
    output int         rounds_pending
);
    import rvs_pkg::*;

    // Voting state as the block should hold it.
    winner_kind_t cur_kind;
    logic [3:0]   cur_slot;
    logic [7:0]   held_rssi;
    logic [7:0]   run_max;
    logic [3:0]   run_best_slot;
    logic         run_has_link;
    logic [7:0]   voted_seen;
    logic         in_round;
    logic         lat_keyed;
    logic [7:0]   lat_lrssi;
    logic [7:0]   margin;

    result_t      vote_q[$];

    // Advances the voting state by one report; returns 1 when the report closes a round.
    function automatic bit vote_on_report(input in_item_t it, output result_t res);
        logic [7:0] voted;
        logic [8:0] bar;
        bit         elect;
        res = '0;
        if (!in_round)
        begin
            lat_keyed     = it.local_keyed;
            lat_lrssi     = it.local_rssi;
            run_max       = it.local_keyed ? it.local_rssi : 8'd0;
            run_best_slot = '0;
            run_has_link  = 1'b0;
            voted_seen    = '0;
        end
        if (it.link_present && it.link_receiving && (it.link_slot < MAX_LINKS))
        begin
            if (it.link_rssi > run_max)
            begin
                run_max       = it.link_rssi;
                run_best_slot = it.link_slot;
                run_has_link  = 1'b1;
            end
            if (cur_kind == KIND_LINK && it.link_slot == cur_slot)
                voted_seen = it.link_rssi;
        end
        if (!it.last_in_round)
        begin
            in_round = 1'b1;
            return 1'b0;
        end
        in_round = 1'b0;

        voted = '0;
        if (cur_kind == KIND_LOCAL && lat_keyed)
            voted = lat_lrssi;
        else if (cur_kind == KIND_LINK)
            voted = voted_seen;

        // The hysteresis bar is one bit wider so it never wraps.
        bar   = {1'b0, voted} + {1'b0, margin};
        elect = (voted == 8'd0) || (cur_kind == KIND_NONE) || ({1'b0, run_max} > bar);
        if (elect)
        begin
            if (run_has_link)
            begin
                cur_kind = KIND_LINK;
                cur_slot = run_best_slot;
            end
            else
            begin
                cur_kind = lat_keyed ? KIND_LOCAL : KIND_NONE;
                cur_slot = '0;
            end
            voted = run_max;
        end
        held_rssi = voted;

        res.winner_kind = cur_kind;
        res.winner_slot = (cur_kind == KIND_LINK) ? cur_slot : 4'd0;
        res.vote_level  = held_rssi;
        res.best_rssi   = run_max;
        res.new_winner  = elect;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $realtime, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t predicted;
        result_t want;
        if (!rst_n)
        begin
            cur_kind      = KIND_NONE;
            cur_slot      = '0;
            held_rssi     = '0;
            run_max       = '0;
            run_best_slot = '0;
            run_has_link  = 1'b0;
            voted_seen    = '0;
            in_round      = 1'b0;
            lat_keyed     = 1'b0;
            lat_lrssi     = '0;
            margin        = '0;
            mismatches    = 0;
            vote_q.delete();
            rounds_pending <= 0;
        end
        else
        begin
            if (cfg_we)
                margin = cfg_wdata;
            if (item.valid && item.ready)
            begin
                if (vote_on_report(item.data, predicted))
                    vote_q.push_back(predicted);
            end
            if (result.valid && result.ready)
            begin
                if (vote_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with none expected, got %h", $realtime, result.data);
                end
                else
                begin
                    want = vote_q.pop_front();
                    check_field("winner_kind", want.winner_kind, result.data.winner_kind);
                    check_field("winner_slot", want.winner_slot, result.data.winner_slot);
                    check_field("vote_level", want.vote_level, result.data.vote_level);
                    check_field("best_rssi", want.best_rssi, result.data.best_rssi);
                    check_field("new_winner", want.new_winner, result.data.new_winner);
                end
            end
            rounds_pending <= vote_q.size();
        end
    end

endmodule

// File: bench/rssi_voter_select_tb.sv
`timescale 1ns / 1ps
// Top of the voter select testbench: clock, reset, stimulus, back-pressure and verdict.
module rssi_voter_select_tb;
    import rvs_pkg::*;

    localparam int HALF_PERIOD    = 10;
    // Settling time after the last predicted result has come back, to cover any stragglers.
    localparam int SETTLE_CYCLES  = 6;
    localparam int RX_HOLD_CYCLES = 120;
    localparam int PHASE_ITEMS    = 145;
    localparam int PRESSURE_ITEMS = 40;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    rvs_in_if  in_bus ();
    rvs_out_if res_bus ();

    int fail_count;
    int pending_rounds;
    int items_sent = 0;

    // Tracks whether valid is currently being raised, so that it is never lowered
    // twice within one time step.
    bit offering = 1'b0;
    // Handshake between stimulus and receiver for the long hold-off.
    bit rx_hold_req = 1'b0;
    bit rx_holding  = 1'b0;

    rssi_voter_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (in_bus),
        .result    (res_bus)
    );

    rssi_voter_select_checker u_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .item           (in_bus),
        .result         (res_bus),
        .mismatches     (fail_count),
        .rounds_pending (pending_rounds)
    );

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("rssi_voter_select_tb: done, errors");
        $finish;
    end

    // Idle stretches: mostly short, now and then a long one.
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Strengths cluster around a per-round level so that the hysteresis margin
    // actually decides elections; the extremes show up often on their own.
    function automatic logic [7:0] level_near(input int base);
        int pick;
        int v;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return 8'd0;
        if (pick < 16)
            return 8'd255;
        if (pick < 70)
        begin
            v = base + int'($urandom_range(0, 40)) - 20;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
            return v[7:0];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // Offers one report and returns at the edge where its transfer takes place.
    task automatic put_item(input in_item_t it);
        in_bus.valid <= 1'b1;
        in_bus.data  <= it;
        offering = 1'b1;
        do
            @(posedge clk);
        while (!in_bus.ready);
        items_sent++;
    endtask

    task automatic stop_offer();
        if (offering)
        begin
            in_bus.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic idle_after(input bit no_gaps);
        if (!no_gaps && $urandom_range(0, 99) < 40)
        begin
            stop_offer();
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task automatic put_report(input bit present, input logic [3:0] slot, input bit recv,
                              input logic [7:0] rssi, input bit keyed,
                              input logic [7:0] lrssi, input bit last);
        in_item_t it;
        it.link_present   = present;
        it.link_slot      = slot;
        it.link_receiving = recv;
        it.link_rssi      = rssi;
        it.local_keyed    = keyed;
        it.local_rssi     = lrssi;
        it.last_in_round  = last;
        put_item(it);
        idle_after(1'b0);
    endtask

    // One voting round of random content. A noisy round has every field but
    // last_in_round scrambled, so link_present is often low and slots are spread wide.
    task automatic send_round(input int len, input bit no_gaps, input bit noisy);
        in_item_t it;
        int       base;
        base = $urandom_range(0, 255);
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                it = in_item_t'(24'($urandom));
            else
            begin
                it.link_present   = ($urandom_range(0, 9) != 0);
                it.link_slot      = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                                                : 4'($urandom_range(0, 15));
                it.link_receiving = ($urandom_range(0, 4) != 0);
                it.link_rssi      = level_near(base);
                it.local_keyed    = ($urandom_range(0, 2) != 0);
                it.local_rssi     = level_near(base);
            end
            it.last_in_round = (i == len - 1);
            put_item(it);
            idle_after(no_gaps);
        end
    endtask

    task automatic random_round(input bit no_gaps);
        int len;
        len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 5) : $urandom_range(6, 16);
        send_round(len, no_gaps || ($urandom_range(0, 4) == 0), $urandom_range(0, 9) == 0);
    endtask

    // Waits until every predicted result has come back, then lets the pipeline settle.
    task automatic drain();
        stop_offer();
        @(posedge clk);
        while (pending_rounds != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_margin(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result receiver: ready comes in bursts broken by stalls. On request it
    // holds off for a long stretch so the block fills up and stalls its input.
    initial
    begin
        int run;
        res_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                rx_holding  = 1'b1;
                res_bus.ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                rx_holding = 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
                repeat (run) @(posedge clk);
                if ($urandom_range(0, 99) < 45)
                begin
                    res_bus.ready <= 1'b0;
                    repeat (gap_len()) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int margins [7];
        int goal;
        margins = '{0, 255, 1, 12, 40, -1, -1};

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        in_bus.valid <= 1'b0;
        in_bus.data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rounds with no margin.
        set_margin(8'd0);
        // An empty round with nothing keyed elects nobody.
        put_report(1'b0, 4'd0, 1'b0, 8'd0, 1'b0, 8'd0, 1'b1);
        // A link tying the local receiver loses to it; so does a later equal link.
        put_report(1'b1, 4'd3, 1'b1, 8'd100, 1'b1, 8'd100, 1'b0);
        put_report(1'b1, 4'd15, 1'b1, 8'd100, 1'b0, 8'd0, 1'b1);
        // A stronger link takes over; a report-free item with junk fields changes nothing.
        put_report(1'b1, 4'd5, 1'b1, 8'd150, 1'b1, 8'd100, 1'b0);
        put_report(1'b0, 4'd0, 1'b1, 8'd255, 1'b0, 8'd0, 1'b1);
        // The voted link stays silent, so its strength counts as zero and the
        // keyed local receiver is elected; a strong but not receiving link is ignored.
        put_report(1'b1, 4'd6, 1'b0, 8'd255, 1'b1, 8'd200, 1'b1);
        // The local winner drops its carrier, so a weak link takes over.
        put_report(1'b1, 4'd2, 1'b1, 8'd50, 1'b0, 8'd255, 1'b1);
        // The voted slot reports twice: its last report gives the refreshed strength.
        put_report(1'b1, 4'd2, 1'b1, 8'd80, 1'b0, 8'd0, 1'b0);
        put_report(1'b1, 4'd2, 1'b1, 8'd30, 1'b1, 8'd255, 1'b0);
        put_report(1'b1, 4'd7, 1'b1, 8'd60, 1'b0, 8'd0, 1'b1);
        // An equal challenger at full strength does not displace the winner.
        put_report(1'b1, 4'd0, 1'b1, 8'd255, 1'b0, 8'd0, 1'b0);
        put_report(1'b1, 4'd2, 1'b1, 8'd255, 1'b0, 8'd0, 1'b1);
        drain();

        // Full margin: held plus margin must not wrap around eight bits.
        set_margin(8'd255);
        put_report(1'b1, 4'd2, 1'b1, 8'd200, 1'b1, 8'd255, 1'b0);
        put_report(1'b1, 4'd9, 1'b1, 8'd255, 1'b0, 8'd0, 1'b1);
        put_report(1'b1, 4'd2, 1'b1, 8'd1, 1'b0, 8'd0, 1'b0);
        put_report(1'b1, 4'd4, 1'b1, 8'd255, 1'b0, 8'd0, 1'b1);
        // The voted slot is missing, so a re-election happens regardless of margin.
        put_report(1'b1, 4'd4, 1'b1, 8'd255, 1'b1, 8'd0, 1'b1);
        drain();

        // Random phases, each under its own margin, the extremes among them.
        for (int p = 0; p < 7; p++)
        begin
            set_margin((margins[p] < 0) ? 8'($urandom_range(0, 255)) : 8'(margins[p]));
            goal = items_sent + PHASE_ITEMS;
            if (p == 3)
            begin
                // Back-to-back short rounds while the receiver holds off: the
                // pending result and the closing report back up into the input.
                rx_hold_req = 1'b1;
                wait (rx_holding);
                goal = items_sent + PRESSURE_ITEMS;
                while (items_sent < goal)
                    send_round($urandom_range(1, 2), 1'b1, 1'b0);
                goal = items_sent + PHASE_ITEMS;
            end
            while (items_sent < goal)
                random_round($urandom_range(0, 4) == 0);
            drain();
        end

        if (fail_count == 0)
            $display("rssi_voter_select_tb: done, clean");
        else
            $display("rssi_voter_select_tb: done, errors");
        $finish;
    end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/rvs_pkg.sv
hw/rtl/rvs_in_if.sv
hw/rtl/rvs_out_if.sv
hw/rtl/rvs_in_stage.sv
hw/rtl/rvs_vote.sv
hw/rtl/rssi_voter_select.sv
bench/rssi_voter_select_checker.sv
bench/rssi_voter_select_tb.sv
